// File: rtl/bracket_balance_checker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bracket balance checker.
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and codes shared by the bracket balance checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

	localparam logic [1:0] KIND_ROUND  = 2'd0;
	localparam logic [1:0] KIND_CURLY  = 2'd1;
	localparam logic [1:0] KIND_SQUARE = 2'd2;

	localparam logic [2:0] ERR_OK         = 3'd0;
	localparam logic [2:0] ERR_UNMATCHED  = 3'd1;
	localparam logic [2:0] ERR_WRONG_KIND = 3'd2;
	localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [1:0] kind;
		logic       last;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [2:0] error_kind;
		logic       well_formed;
	} verdict_t;

endpackage

`default_nettype wire

// File: rtl/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input words, decodes brackets and stages operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_char,
	input  wire logic          in_last,
	input  wire bbc_pkg::q_stat_t q_stat,
	output logic               q_push,
	output bbc_pkg::op_t       q_op
);
	import bbc_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_d;
	logic in_fire;
	logic keep;

	always_comb begin
		op_d = '{push: 1'b0, pop: 1'b0, kind: KIND_ROUND, last: in_last};
		case (in_char)
			CH_OPEN_ROUND: begin
				op_d.push = 1'b1;
				op_d.kind = KIND_ROUND;
			end
			CH_OPEN_CURLY: begin
				op_d.push = 1'b1;
				op_d.kind = KIND_CURLY;
			end
			CH_OPEN_SQUARE: begin
				op_d.push = 1'b1;
				op_d.kind = KIND_SQUARE;
			end
			CH_CLOSE_ROUND: begin
				op_d.pop  = 1'b1;
				op_d.kind = KIND_ROUND;
			end
			CH_CLOSE_CURLY: begin
				op_d.pop  = 1'b1;
				op_d.kind = KIND_CURLY;
			end
			CH_CLOSE_SQUARE: begin
				op_d.pop  = 1'b1;
				op_d.kind = KIND_SQUARE;
			end
			default: begin
				op_d.push = 1'b0;
			end
		endcase
	end

	// Words that are neither brackets nor final carry no work and are dropped here.
	assign keep     = op_d.push | op_d.pop | op_d.last;
	assign q_push   = valid_s1 & ~q_stat.full;
	assign in_ready = ~valid_s1 | ~q_stat.full;
	assign in_fire  = in_valid & in_ready;
	assign q_op     = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= keep;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1 <= op_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Short FIFO of decoded operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire bbc_pkg::op_t     wr_op,
	input  wire logic             rd_en,
	output bbc_pkg::op_t          rd_op,
	output bbc_pkg::q_stat_t      stat
);
	import bbc_pkg::*;

	op_t                 entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en & ~stat.full;
	assign do_rd      = rd_en & ~stat.empty;
	assign rd_op      = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Executes bracket operations on the opener stack and issues verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_back #(
	parameter int STACK_DEPTH = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	input  wire bbc_pkg::op_t  op,
	output logic               op_take,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bbc_pkg::verdict_t  out_verdict
);
	import bbc_pkg::*;

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// The top entry lives in top_q; below_q holds the entry under it, read from the stack memory in the cycle before.
	logic [1:0]    stack_mem [STACK_DEPTH];
	logic [LW-1:0] level_q;
	logic [1:0]    top_q;
	logic [1:0]    below_q;
	logic [2:0]    fail_q;
	logic          out_valid_q;
	verdict_t      out_verdict_q;

	logic          fire;
	logic          wr_en;
	logic [LW-1:0] level_d;
	logic [LW-1:0] level_n;
	logic [LW-1:0] rd_level;
	logic [1:0]    top_d;
	logic [2:0]    fail_d;
	logic [2:0]    fail_n;
	verdict_t      verdict_d;

	assign fire    = op_valid & (~op.last | ~out_valid_q | out_ready);
	assign op_take = fire;

	always_comb begin
		level_d = level_q;
		fail_d  = fail_q;
		top_d   = top_q;
		wr_en   = 1'b0;
		if (fire && fail_q == ERR_OK) begin
			if (op.push) begin
				if (level_q == LW'(STACK_DEPTH)) begin
					fail_d = ERR_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					level_d = level_q + LW'(1);
					top_d   = op.kind;
				end
			end else if (op.pop) begin
				if (level_q == '0) begin
					fail_d = ERR_UNMATCHED;
				end else if (top_q != op.kind) begin
					fail_d = ERR_WRONG_KIND;
				end else begin
					level_d = level_q - LW'(1);
					top_d   = below_q;
				end
			end
		end

		if (fail_d != ERR_OK) begin
			verdict_d.error_kind = fail_d;
		end else if (level_d != '0) begin
			verdict_d.error_kind = ERR_UNCLOSED;
		end else begin
			verdict_d.error_kind = ERR_OK;
		end
		verdict_d.well_formed = (verdict_d.error_kind == ERR_OK);

		level_n = level_d;
		fail_n  = fail_d;
		if (fire && op.last) begin
			level_n = '0;
			fail_n  = ERR_OK;
		end
		rd_level = level_n - LW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			fail_q      <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			level_q <= level_n;
			fail_q  <= fail_n;
			if (fire && op.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (fire && op.last) begin
			out_verdict_q <= verdict_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[level_q[AW-1:0]] <= op.kind;
		end
		below_q <= stack_mem[rd_level[AW-1:0]];
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = out_verdict_q;

endmodule

`default_nettype wire

// File: rtl/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Streaming check that round, curly and square brackets are balanced.
// ----------------------------------------------------------------------------
// The input stream carries one text byte per word, with tlast on the final
// byte of an expression. Each final byte produces exactly one output word with
// the verdict; other bytes produce nothing. Bytes that are not brackets cost
// no stack access.
// The block accepts one word per clock while s_axis_tready is high. When a
// final byte is accepted, the decode register loads it, the word then enters
// the queue and the stack unit, which does one stack access per cycle unless
// stalled, registers the verdict in the output register. A four-word queue
// separates decoding from stack execution, so the input keeps flowing for a
// few words while the output is stalled. When the receiver holds tready low,
// the verdict waits in the output register and the stack unit stops only at
// the next final byte; the queue then fills and s_axis_tready falls.
// Reset empties the stack, the queue and the output register and clears the
// failure code. The stack memory itself is not cleared, since only entries
// pushed within the current expression are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker #(
	parameter int STACK_DEPTH = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	// Bits 7:0 char_code.
	input  wire logic [7:0] s_axis_tdata,
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	// Bit 0 well_formed, bits 3:1 error_kind, bits 7:4 zero.
	output logic [7:0]      m_axis_tdata
);
	import bbc_pkg::*;

	q_stat_t  q_stat;
	logic     q_push;
	op_t      q_wr_op;
	op_t      q_rd_op;
	logic     q_pop;
	verdict_t verdict;

	bbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_op     (q_wr_op)
	);

	bbc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_op  (q_wr_op),
		.rd_en  (q_pop),
		.rd_op  (q_rd_op),
		.stat   (q_stat)
	);

	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (~q_stat.empty),
		.op          (q_rd_op),
		.op_take     (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_verdict (verdict)
	);

	assign m_axis_tdata = {4'b0000, verdict.error_kind, verdict.well_formed};

endmodule

`default_nettype wire

// File: rtl/bbc_checker.sv
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level assertions for the bracket balance checker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bracket_balance_checker_defines.svh"

module bbc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	`BBC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Output word changed while stalled.")
	`BBC_ASSERT_SAME(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[7:4] == 4'b0000, "Output padding bits are not zero.")
	`BBC_ASSERT_SAME(a_ok_match, clk, arst_n, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[3:1] == 3'd0), "Success flag disagrees with error kind.")
	`BBC_ASSERT_SAME(a_kind_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[3:1] <= 3'd4, "Error kind out of range.")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
